/* src/cpn_pkg.sv */
// ============================================================================
// cpn_pkg: shared types and constants for the cross product over norm block
// Sequencer states, shared unit op codes, the control and status bundles
// passed between the sequencer and the datapath, and the fixed widths.
// ============================================================================
package cpn_pkg;

  // Field and datapath widths.
  localparam int CODE_W  = 16;  // excess-4096 input code
  localparam int MAG_W   = 12;  // clipped magnitude, at most 4064
  localparam int WORK_W  = 29;  // widest value: ten times the cross difference
  localparam int NORM_W  = 16;  // norm of g after the final left shift
  localparam int OUT_W   = 16;  // result field
  localparam int MUL_A_W = 26;  // multiplier operand widths
  localparam int MUL_B_W = 12;
  localparam int CNT_W   = 5;   // iteration counter

  // Component decode constants.
  localparam logic [CODE_W-1:0] EXCESS   = 16'd4096;
  localparam logic [CODE_W-1:0] CODE_HI  = 16'd8160;
  localparam logic [CODE_W-1:0] CODE_LO  = 16'd32;
  localparam logic [MAG_W-1:0]  MAG_CLIP = 12'd4064;

  // Normalization stops once a magnitude has this bit or a higher one set.
  localparam int NORM_BIT = 10;

  // Norm and quotient scaling.
  localparam int SUM_SHIFT  = 10;
  localparam int SCALE_SQRT = 100;
  localparam int SCALE_OUT  = 10;
  localparam int NORM_SHIFT = 5;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

  // Iteration counts: one root bit per step, one quotient bit per step.
  localparam int SQRT_STEPS = 11;
  localparam int DIV_STEPS  = 29;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ1,
    ST_SQ2,
    ST_SSUM,
    ST_SCALE,
    ST_SQRT,
    ST_CL,
    ST_CR,
    ST_MIX,
    ST_MIX2,
    ST_TEN,
    ST_DIV,
    ST_DONE
  } cpn_state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } cpn_alu_op_t;

  typedef struct packed {
    logic [WORK_W-1:0] value;
    logic              ge;     // first operand not below the second
  } cpn_alu_res_t;

  typedef struct packed {
    cpn_state_t        state;
    cpn_alu_op_t       alu_op;
    logic [CNT_W-1:0]  cnt;
  } cpn_ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic g_zero;
    logic g_small;
    logic mix_add;
    logic alu_ge;
    logic out_free;
  } cpn_stat_t;

endpackage

/* src/cross_product_over_norm_x10_core.sv */
// ============================================================================
// cross_product_over_norm_x10_core: perpendicular component of a over |g|
// Computes ten times |a x g| divided by a scaled norm of g, saturated to
// 16 bits, with one shared multiply/add/subtract unit under a sequencer.
// ============================================================================
//
//   channel  direction  payload (lowest bits first)
//   in_      slave      accel_x, accel_y, grav_x, grav_y (16 bits each)
//   out_     master     perp_x10 (16 bits)
//
// An item occupies the block while k doublings (k from 0 to 10) normalize g,
// the square root and cross terms are formed, an extra swapped subtraction
// runs when the cross difference is negative, and the restoring divide runs;
// a zero g goes straight to the result. The divide and the root dominate.
// in_tready is high only in the idle state; a finished result moves into the
// output register as the block returns to idle, and waits there for out_tready.
// Reset is synchronous and active low and clears the sequencer and out_tvalid.
//
module cross_product_over_norm_x10_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // accel_x, accel_y, grav_x, grav_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // perp_x10
);
  import cpn_pkg::*;

  cpn_ctrl_t    ctrl;
  cpn_stat_t    stat;
  cpn_alu_op_t  alu_op;
  cpn_alu_res_t alu_res;
  logic [WORK_W-1:0] alu_a;
  logic [WORK_W-1:0] alu_b;

  logic [MAG_W-1:0] a1_mag, a2_mag, g1_mag, g2_mag;
  logic             a1_neg, a2_neg, g1_neg, g2_neg;

  logic [MAG_W-1:0]  a1_r, a2_r, g1_r, g2_r;
  logic [MAG_W-1:0]  a1_nxt, a2_nxt, g1_nxt, g2_nxt;
  logic              lneg_r, rneg_r, lneg_nxt, rneg_nxt;
  logic [WORK_W-1:0] acc_r, acc_nxt;
  logic [WORK_W-1:0] tmp_r, tmp_nxt;
  logic [NORM_W-1:0] norm_r, norm_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic              in_fire;
  logic              out_free;
  logic [WORK_W-1:0] sqrt_bit;
  logic [NORM_W:0]   div_trial;
  logic [OUT_W-1:0]  sat_q;

  // Component decode of the incoming transfer.
  cpn_decode u_dec_a1 (.code(in_tdata[15:0]),  .mag(a1_mag), .neg(a1_neg));
  cpn_decode u_dec_a2 (.code(in_tdata[31:16]), .mag(a2_mag), .neg(a2_neg));
  cpn_decode u_dec_g1 (.code(in_tdata[47:32]), .mag(g1_mag), .neg(g1_neg));
  cpn_decode u_dec_g2 (.code(in_tdata[63:48]), .mag(g2_mag), .neg(g2_neg));

  // Handshake.
  assign in_tready = (ctrl.state == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid_r | out_tready;

  // Status to the sequencer.
  assign stat.in_fire  = in_fire;
  assign stat.g_zero   = (g1_mag == '0) && (g2_mag == '0);
  assign stat.g_small  = (g1_r[MAG_W-1:NORM_BIT] == '0) && (g2_r[MAG_W-1:NORM_BIT] == '0);
  assign stat.mix_add  = lneg_r ^ rneg_r;
  assign stat.alu_ge   = alu_res.ge;
  assign stat.out_free = out_free;

  cpn_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign alu_op = ctrl.alu_op;

  cpn_alu u_alu (
    .op   (alu_op),
    .op_a (alu_a),
    .op_b (alu_b),
    .res  (alu_res)
  );

  // Root trial bit is four to the power of the remaining step count.
  assign sqrt_bit  = WORK_W'(1) << {ctrl.cnt, 1'b0};
  // Partial remainder with the next dividend bit shifted in.
  assign div_trial = {tmp_r[NORM_W-1:0], acc_r[WORK_W-1]};
  assign sat_q     = (acc_r[WORK_W-1:OUT_W] != '0) ? OUT_MAX : acc_r[OUT_W-1:0];

  // Operand selection for the shared unit.
  always_comb begin
    alu_a = acc_r;
    alu_b = tmp_r;
    case (ctrl.state)
      ST_SQ1: begin
        alu_a = WORK_W'(g1_r);
        alu_b = WORK_W'(g1_r);
      end
      ST_SQ2: begin
        alu_a = WORK_W'(g2_r);
        alu_b = WORK_W'(g2_r);
      end
      ST_SCALE: begin
        alu_a = acc_r >> SUM_SHIFT;
        alu_b = WORK_W'(SCALE_SQRT);
      end
      ST_SQRT: begin
        alu_a = acc_r;
        alu_b = tmp_r | sqrt_bit;
      end
      ST_CL: begin
        alu_a = WORK_W'(a1_r);
        alu_b = WORK_W'(g2_r);
      end
      ST_CR: begin
        alu_a = WORK_W'(g1_r);
        alu_b = WORK_W'(a2_r);
      end
      ST_MIX2: begin
        alu_a = tmp_r;
        alu_b = acc_r;
      end
      ST_TEN: begin
        alu_a = acc_r;
        alu_b = WORK_W'(SCALE_OUT);
      end
      ST_DIV: begin
        alu_a = WORK_W'(div_trial);
        alu_b = WORK_W'(norm_r);
      end
      default: begin
        alu_a = acc_r;
        alu_b = tmp_r;
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    a1_nxt   = a1_r;
    a2_nxt   = a2_r;
    g1_nxt   = g1_r;
    g2_nxt   = g2_r;
    lneg_nxt = lneg_r;
    rneg_nxt = rneg_r;
    acc_nxt  = acc_r;
    tmp_nxt  = tmp_r;
    norm_nxt = norm_r;
    case (ctrl.state)
      ST_IDLE: begin
        if (in_fire) begin
          a1_nxt   = a1_mag;
          a2_nxt   = a2_mag;
          g1_nxt   = g1_mag;
          g2_nxt   = g2_mag;
          lneg_nxt = a1_neg ^ g2_neg;
          rneg_nxt = g1_neg ^ a2_neg;
          acc_nxt  = '0;
        end
      end
      ST_NORM: begin
        if (stat.g_small) begin
          g1_nxt = {g1_r[MAG_W-2:0], 1'b0};
          g2_nxt = {g2_r[MAG_W-2:0], 1'b0};
        end
      end
      ST_SQ1:  acc_nxt = alu_res.value;
      ST_SQ2:  tmp_nxt = alu_res.value;
      ST_SSUM: acc_nxt = alu_res.value;
      ST_SCALE: begin
        acc_nxt = alu_res.value;
        tmp_nxt = '0;
      end
      ST_SQRT: begin
        // Remainder in acc, developing root in tmp.
        if (alu_res.ge) begin
          acc_nxt = alu_res.value;
          tmp_nxt = (tmp_r >> 1) | sqrt_bit;
        end else begin
          tmp_nxt = tmp_r >> 1;
        end
      end
      ST_CL: begin
        acc_nxt  = alu_res.value;
        norm_nxt = {tmp_r[NORM_W-NORM_SHIFT-1:0], {NORM_SHIFT{1'b0}}};
      end
      ST_CR:   tmp_nxt = alu_res.value;
      ST_MIX: begin
        // The left product stays in acc when the difference would go negative.
        if (stat.mix_add || alu_res.ge) begin
          acc_nxt = alu_res.value;
        end
      end
      ST_MIX2: acc_nxt = alu_res.value;
      ST_TEN: begin
        acc_nxt = alu_res.value;
        tmp_nxt = '0;
      end
      ST_DIV: begin
        // Dividend shifts out of acc as quotient bits shift in.
        tmp_nxt = alu_res.ge ? alu_res.value : WORK_W'(div_trial);
        acc_nxt = {acc_r[WORK_W-2:0], alu_res.ge};
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // Output register: a new result loads when it is empty or as the held one leaves.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    if ((ctrl.state == ST_DONE) && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = sat_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a1_r        <= a1_nxt;
    a2_r        <= a2_nxt;
    g1_r        <= g1_nxt;
    g2_r        <= g2_nxt;
    lneg_r      <= lneg_nxt;
    rneg_r      <= rneg_nxt;
    acc_r       <= acc_nxt;
    tmp_r       <= tmp_nxt;
    norm_r      <= norm_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* src/cpn_decode.sv */
// ============================================================================
// cpn_decode: excess-4096 component decode
// Splits one code into a sign and a magnitude clipped to 4064.
// ============================================================================
module cpn_decode (
  input  logic [cpn_pkg::CODE_W-1:0] code,
  output logic [cpn_pkg::MAG_W-1:0]  mag,
  output logic                       neg
);
  import cpn_pkg::*;

  logic [CODE_W-1:0] pos_val;
  logic [CODE_W-1:0] neg_val;

  assign pos_val = code - EXCESS;
  assign neg_val = EXCESS - code;

  // Codes far outside the usable span clip to the largest magnitude.
  always_comb begin
    if (code >= EXCESS) begin
      neg = 1'b0;
      mag = (code > CODE_HI) ? MAG_CLIP : pos_val[MAG_W-1:0];
    end else begin
      neg = 1'b1;
      mag = (code < CODE_LO) ? MAG_CLIP : neg_val[MAG_W-1:0];
    end
  end

endmodule

/* src/cpn_alu.sv */
// ============================================================================
// cpn_alu: shared arithmetic unit
// One multiplier, one adder and one subtract-compare, selected by op code.
// ============================================================================
module cpn_alu (
  input  cpn_pkg::cpn_alu_op_t         op,
  input  logic [cpn_pkg::WORK_W-1:0]   op_a,
  input  logic [cpn_pkg::WORK_W-1:0]   op_b,
  output cpn_pkg::cpn_alu_res_t        res
);
  import cpn_pkg::*;

  logic [MUL_A_W+MUL_B_W-1:0] prod;
  logic [WORK_W:0]            dif;
  logic [WORK_W-1:0]          sum;

  assign prod = op_a[MUL_A_W-1:0] * op_b[MUL_B_W-1:0];
  assign dif  = {1'b0, op_a} - {1'b0, op_b};
  assign sum  = op_a + op_b;

  always_comb begin
    // The compare flag comes from the subtractor borrow for every op.
    res.ge = ~dif[WORK_W];
    case (op)
      ALU_ADD: res.value = sum;
      ALU_SUB: res.value = dif[WORK_W-1:0];
      ALU_MUL: res.value = prod[WORK_W-1:0];
      default: res.value = sum;
    endcase
  end

endmodule

/* src/cpn_seq.sv */
// ============================================================================
// cpn_seq: sequencer
// Steps one item through normalize, square sum, root, cross terms and divide.
// ============================================================================
module cpn_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  cpn_pkg::cpn_stat_t stat,
  output cpn_pkg::cpn_ctrl_t ctrl
);
  import cpn_pkg::*;

  cpn_state_t       state_r;
  cpn_state_t       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  cpn_alu_op_t      alu_op;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (stat.in_fire) begin
          state_nxt = stat.g_zero ? ST_DONE : ST_NORM;
        end
      end
      ST_NORM: begin
        if (!stat.g_small) begin
          state_nxt = ST_SQ1;
        end
      end
      ST_SQ1:   state_nxt = ST_SQ2;
      ST_SQ2:   state_nxt = ST_SSUM;
      ST_SSUM:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_CL;
        end
      end
      ST_CL: state_nxt = ST_CR;
      ST_CR: state_nxt = ST_MIX;
      ST_MIX: begin
        // A negative difference is redone with the operands swapped.
        state_nxt = (!stat.mix_add && !stat.alu_ge) ? ST_MIX2 : ST_TEN;
      end
      ST_MIX2: state_nxt = ST_TEN;
      ST_TEN:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Iteration counter for the root and divide loops.
  always_comb begin
    cnt_nxt = cnt_r;
    case (state_r)
      ST_SCALE: cnt_nxt = CNT_W'(SQRT_STEPS - 1);
      ST_TEN:   cnt_nxt = CNT_W'(DIV_STEPS - 1);
      ST_SQRT:  cnt_nxt = cnt_r - CNT_W'(1);
      ST_DIV:   cnt_nxt = cnt_r - CNT_W'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // Shared unit operation for each state.
  always_comb begin
    case (state_r)
      ST_SQ1:   alu_op = ALU_MUL;
      ST_SQ2:   alu_op = ALU_MUL;
      ST_SCALE: alu_op = ALU_MUL;
      ST_CL:    alu_op = ALU_MUL;
      ST_CR:    alu_op = ALU_MUL;
      ST_TEN:   alu_op = ALU_MUL;
      ST_SQRT:  alu_op = ALU_SUB;
      ST_DIV:   alu_op = ALU_SUB;
      ST_MIX2:  alu_op = ALU_SUB;
      ST_MIX:   alu_op = stat.mix_add ? ALU_ADD : ALU_SUB;
      default:  alu_op = ALU_ADD;
    endcase
  end

  assign ctrl.state  = state_r;
  assign ctrl.alu_op = alu_op;
  assign ctrl.cnt    = cnt_r;

endmodule

/* src/cpn_checker.sv */
// ============================================================================
// cpn_checker: port-level assertions for the cross product over norm block
// Watches the handshakes of the top level and is bound to it below.
// ============================================================================
module cpn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // The block is busy in the cycle after an input transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after an input transfer");

  // A new result appears only as the block returns to accepting input.
  a_result_with_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while the block was still busy");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or was dropped");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind cross_product_over_norm_x10_core cpn_checker u_cpn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
